// File: rtl/core/ifmt_pkg.sv
// ifmt_pkg: shared types and constants for the integer field formatter.
// Beat payload structs, sequencer state encoding, divider status, ASCII codes.
// No dependencies.
`timescale 1ns / 1ps

package ifmt_pkg;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  radix;
    logic        upper_case;
    logic [1:0]  sign_kind;
    logic [1:0]  prefix_kind;
    logic        left_justify;
    logic        zero_pad;
    logic        has_precision;
    logic [5:0]  precision;
    logic [5:0]  field_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  localparam int DIGIT_W = 4;

  // divider -> sequencer status
  typedef struct packed {
    logic               digit_vld;
    logic [DIGIT_W-1:0] digit;
    logic               done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_CALC,
    S_LPAD,
    S_SIGN,
    S_PFX,
    S_ZPAD,
    S_PZERO,
    S_DIGIT,
    S_RPAD
  } state_t;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_MINUS = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;
  localparam logic [1:0] SIGN_SPACE = 2'd3;

  localparam logic [1:0] PFX_NONE  = 2'd0;
  localparam logic [1:0] PFX_LOWER = 2'd1;
  localparam logic [1:0] PFX_UPPER = 2'd2;

  localparam logic [4:0] RADIX_MIN = 5'd8;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_UA    = 8'h41;

endpackage

// File: rtl/core/integer_field_formatter_unit.sv
// Integer field formatter top level: printf-style integer conversion into a
// character stream. Depends on ifmt_pkg, ifmt_divider, ifmt_digit_stack.
`timescale 1ns / 1ps

// One input beat (value, radix 8..16, sign/prefix/justify/pad/precision options)
// turns into a run of output beats, one ASCII character each, with last set on
// the final one; a zero value with explicit precision 0 and nothing else to show
// gives no output beats at all. Items are handled one at a time: in_stall stays
// high from acceptance until the last character has been loaded into the output
// register. Digit extraction divides one nibble per cycle and makes one full pass
// over the value per digit; characters then leave as out_stall allows.

module integer_field_formatter_unit #(
  parameter int VALUE_BITS    = 64,
  parameter int MAX_WIDTH     = 48,
  parameter int MAX_PRECISION = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ifmt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ifmt_pkg::out_item_t  out_data
);
  import ifmt_pkg::*;

  localparam int MAX_DIG = (VALUE_BITS + 2) / 3;
  localparam int LEN_W   = $clog2(MAX_WIDTH + MAX_PRECISION + MAX_DIG + 4);

  state_t state_r, state_nxt;

  logic             upper_r;
  logic [1:0]       sign_r;
  logic [1:0]       pfx_r;
  logic             left_r;
  logic             zpad_r;
  logic [LEN_W-1:0] prec_r;
  logic [LEN_W-1:0] width_r;
  logic [LEN_W-1:0] ndig_r;
  logic [LEN_W-1:0] pz_r;
  logic [LEN_W-1:0] pad_r;
  logic [LEN_W-1:0] remain_r;
  logic [LEN_W-1:0] cnt_r;

  logic      out_valid_r;
  out_item_t out_item_r;

  div_stat_t          dstat;
  logic [DIGIT_W-1:0] dig_top;

  logic             accept;
  logic             skip_digits;
  logic [4:0]       radix_sat;
  logic [5:0]       prec_sat;
  logic [6:0]       width_sat;
  logic             slot_free;
  logic [LEN_W-1:0] target;
  logic             run_state;
  logic             run_done;
  logic             emit;
  logic [7:0]       ch;
  logic [LEN_W-1:0] pz_calc;
  logic [LEN_W-1:0] core_calc;
  logic [LEN_W-1:0] pad_calc;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    if (in_data.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_data.radix;
    end
    prec_sat  = (in_data.precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                        : in_data.precision;
    width_sat = ({1'b0, in_data.field_width} > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                              : {1'b0, in_data.field_width};
    skip_digits = in_data.has_precision && (prec_sat == 6'd0) &&
                  (in_data.value[VALUE_BITS-1:0] == '0);
  end

  ifmt_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && !skip_digits),
    .dividend (in_data.value[VALUE_BITS-1:0]),
    .radix    (radix_sat),
    .stat     (dstat)
  );

  ifmt_digit_stack #(
    .DEPTH (MAX_DIG)
  ) u_stack (
    .clk  (clk),
    .push (dstat.digit_vld),
    .pop  (emit && (state_r == S_DIGIT)),
    .din  (dstat.digit),
    .top  (dig_top)
  );

  // field lengths once the digit count is known
  always_comb begin
    pz_calc   = (prec_r > ndig_r) ? (prec_r - ndig_r) : '0;
    core_calc = ndig_r + pz_calc + LEN_W'(sign_r != SIGN_NONE) +
                ((pfx_r != PFX_NONE) ? LEN_W'(2) : '0);
    pad_calc  = (width_r > core_calc) ? (width_r - core_calc) : '0;
  end

  always_comb begin
    target    = '0;
    run_state = 1'b1;
    unique case (state_r)
      S_LPAD:  target = (!left_r && !zpad_r) ? pad_r : '0;
      S_SIGN:  target = LEN_W'(sign_r != SIGN_NONE);
      S_PFX:   target = (pfx_r != PFX_NONE) ? LEN_W'(2) : '0;
      S_ZPAD:  target = zpad_r ? pad_r : '0;
      S_PZERO: target = pz_r;
      S_DIGIT: target = ndig_r;
      S_RPAD:  target = left_r ? pad_r : '0;
      default: run_state = 1'b0;
    endcase
  end

  assign run_done = (cnt_r == target);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = skip_digits ? S_CALC : S_DIV;
      S_DIV:   if (dstat.done) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_LPAD;
      S_LPAD:  if (run_done) state_nxt = S_SIGN;
      S_SIGN:  if (run_done) state_nxt = S_PFX;
      S_PFX:   if (run_done) state_nxt = S_ZPAD;
      S_ZPAD:  if (run_done) state_nxt = S_PZERO;
      S_PZERO: if (run_done) state_nxt = S_DIGIT;
      S_DIGIT: if (run_done) state_nxt = S_RPAD;
      S_RPAD:  if (run_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // character select
  always_comb begin
    emit = run_state && !run_done && slot_free;
    ch   = CHAR_SPACE;
    unique case (state_r)
      S_SIGN: begin
        unique case (sign_r)
          SIGN_MINUS: ch = CHAR_MINUS;
          SIGN_PLUS:  ch = CHAR_PLUS;
          default:    ch = CHAR_SPACE;
        endcase
      end
      S_PFX: begin
        if (cnt_r == '0) begin
          ch = CHAR_ZERO;
        end else begin
          ch = (pfx_r == PFX_UPPER) ? CHAR_UX : CHAR_LX;
        end
      end
      S_ZPAD, S_PZERO: ch = CHAR_ZERO;
      S_DIGIT: begin
        if (dig_top < 4'd10) begin
          ch = CHAR_ZERO + 8'(dig_top);
        end else begin
          ch = (upper_r ? CHAR_UA : CHAR_LA) + 8'(dig_top) - 8'd10;
        end
      end
      default: ch = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else if (emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end

    if (accept) begin
      upper_r  <= in_data.upper_case;
      sign_r   <= in_data.sign_kind;
      pfx_r    <= (in_data.prefix_kind == PFX_UPPER) ? PFX_UPPER :
                  (in_data.prefix_kind == PFX_LOWER) ? PFX_LOWER : PFX_NONE;
      left_r   <= in_data.left_justify;
      zpad_r   <= in_data.zero_pad && !in_data.left_justify && !in_data.has_precision;
      prec_r   <= in_data.has_precision ? LEN_W'(prec_sat) : '0;
      width_r  <= LEN_W'(width_sat);
      ndig_r   <= '0;
    end else if (dstat.digit_vld) begin
      ndig_r <= ndig_r + 1'b1;
    end

    if (state_r == S_CALC) begin
      pz_r     <= pz_calc;
      pad_r    <= pad_calc;
      remain_r <= core_calc + pad_calc;
    end else if (emit) begin
      remain_r <= remain_r - 1'b1;
    end

    if (emit) begin
      out_item_r.out_char <= ch;
      out_item_r.last     <= (remain_r == LEN_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// File: rtl/core/ifmt_divider.sv
// ifmt_divider: nibble-serial long division of the value by the radix.
// One dividend nibble per cycle; each pass yields one digit (the remainder).
// Depends on ifmt_pkg.
`timescale 1ns / 1ps

module ifmt_divider #(
  parameter int VALUE_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [VALUE_BITS-1:0]    dividend,
  input  logic [4:0]               radix,
  output ifmt_pkg::div_stat_t      stat
);
  import ifmt_pkg::*;

  localparam int NIB   = (VALUE_BITS + 3) / 4;
  localparam int DIV_W = NIB * 4;
  localparam int SW    = $clog2(NIB);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic [4:0]       radix_r;
  logic [SW-1:0]    step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             nz_r, nz_nxt;

  logic [8:0] part;
  logic [3:0] qd;
  logic       last_step;
  logic       more;

  // restoring divide of {rem, nibble} by radix, four trial subtracts
  always_comb begin
    part = {1'b0, rem_r, quo_r[DIV_W-1 -: 4]};
    qd   = '0;
    for (int j = 3; j >= 0; j--) begin
      if (part >= (9'(radix_r) << j)) begin
        part  = part - (9'(radix_r) << j);
        qd[j] = 1'b1;
      end
    end
  end

  assign last_step = (step_r == SW'(NIB - 1));
  assign more      = nz_r || (qd != 4'd0);

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    nz_nxt   = nz_r;
    if (start) begin
      quo_nxt  = DIV_W'(dividend);
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      nz_nxt   = 1'b0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-5:0], qd};
      if (last_step) begin
        rem_nxt  = '0;
        step_nxt = '0;
        nz_nxt   = 1'b0;
        busy_nxt = more;
      end else begin
        rem_nxt  = part[3:0];
        step_nxt = step_r + 1'b1;
        nz_nxt   = more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    nz_r  <= nz_nxt;
    if (start) begin
      radix_r <= radix;
    end
  end

  always_comb begin
    stat.digit_vld = busy_r && last_step;
    stat.digit     = part[DIGIT_W-1:0];
    stat.done      = busy_r && last_step && !more;
  end

endmodule

// File: rtl/core/ifmt_digit_stack.sv
// ifmt_digit_stack: shift-register LIFO for digits.
// Digits arrive least significant first and leave most significant first.
// Depends on ifmt_pkg.
`timescale 1ns / 1ps

module ifmt_digit_stack #(
  parameter int DEPTH = 22
) (
  input  logic                         clk,
  input  logic                         push,
  input  logic                         pop,
  input  logic [ifmt_pkg::DIGIT_W-1:0] din,
  output logic [ifmt_pkg::DIGIT_W-1:0] top
);
  import ifmt_pkg::*;

  logic [DIGIT_W-1:0] stk_r [DEPTH];

  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  assign top = stk_r[0];

endmodule

// File: sim/tb_integer_field_formatter_unit.sv
// Testbench for integer_field_formatter_unit: directed table of conversions, then random
// items, each character beat checked against the row's typed text or an in-bench printf-style formatter.
// Depends on ifmt_pkg and the integer_field_formatter_unit RTL.
`timescale 1ns / 1ps

module tb_integer_field_formatter_unit;
  import ifmt_pkg::*;

  localparam int MAX_FIELD     = 48;
  localparam int MAX_PREC      = 40;
  localparam int RANDOM_ITEMS  = 440;
  localparam int QUIET_ITEMS   = 60;
  localparam int DRAIN_CYCLES  = 600;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [1:0] PFX_RSVD  = 2'd3;

  typedef struct {
    in_item_t item;
    bit       typed;
    string    text;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;

  out_item_t  pending_chars[$];
  dir_row_t   dir_rows[$];
  int         errors;
  int         cycles;
  bit         quiet_tail;

  integer_field_formatter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected character run for one accepted item, appended to pending_chars.
  function automatic void format_field(input in_item_t it);
    logic [63:0] v;
    logic [63:0] base;
    logic [3:0]  d;
    logic [7:0]  digs[$];
    logic [7:0]  field[$];
    logic        zfill;
    out_item_t   ex;
    int          prec, width, pzeros, core, pad;
    v = it.value;
    base = 64'(it.radix);
    if (it.radix < RADIX_MIN) base = 64'(RADIX_MIN);
    if (it.radix > RADIX_MAX) base = 64'(RADIX_MAX);
    prec = 0;
    if (it.has_precision) prec = (int'(it.precision) > MAX_PREC) ? MAX_PREC : int'(it.precision);
    width = (int'(it.field_width) > MAX_FIELD) ? MAX_FIELD : int'(it.field_width);
    zfill = it.zero_pad && !it.left_justify && !it.has_precision;
    // explicit zero precision on a zero value shows no digits at all
    if (!(it.has_precision && prec == 0 && v == 64'd0)) begin
      do begin
        d = 4'(v % base);
        if (d < 4'd10) digs.push_front(CHAR_ZERO + 8'(d));
        else digs.push_front((it.upper_case ? CHAR_UA : CHAR_LA) + 8'(d) - 8'd10);
        v = v / base;
      end while (v != 64'd0);
    end
    pzeros = (prec > digs.size()) ? prec - digs.size() : 0;
    core = digs.size() + pzeros + ((it.sign_kind != SIGN_NONE) ? 1 : 0)
         + ((it.prefix_kind == PFX_LOWER || it.prefix_kind == PFX_UPPER) ? 2 : 0);
    pad = (width > core) ? width - core : 0;
    if (!it.left_justify && !zfill) repeat (pad) field.push_back(CHAR_SPACE);
    case (it.sign_kind)
      SIGN_MINUS: field.push_back(CHAR_MINUS);
      SIGN_PLUS:  field.push_back(CHAR_PLUS);
      SIGN_SPACE: field.push_back(CHAR_SPACE);
      default: ;
    endcase
    if (it.prefix_kind == PFX_LOWER || it.prefix_kind == PFX_UPPER) begin
      field.push_back(CHAR_ZERO);
      field.push_back((it.prefix_kind == PFX_UPPER) ? CHAR_UX : CHAR_LX);
    end
    if (zfill) repeat (pad) field.push_back(CHAR_ZERO);
    repeat (pzeros) field.push_back(CHAR_ZERO);
    foreach (digs[i]) field.push_back(digs[i]);
    if (it.left_justify) repeat (pad) field.push_back(CHAR_SPACE);
    foreach (field[i]) begin
      ex.out_char = field[i];
      ex.last = (i == field.size() - 1);
      pending_chars.push_back(ex);
    end
  endfunction

  function automatic in_item_t fmt_item(input logic [63:0] value, input logic [4:0] radix,
                                        input logic up, input logic [1:0] sk,
                                        input logic [1:0] pk, input logic lj, input logic zp,
                                        input logic hp, input logic [5:0] prec,
                                        input logic [5:0] w);
    in_item_t it;
    it.value = value;
    it.radix = radix;
    it.upper_case = up;
    it.sign_kind = sk;
    it.prefix_kind = pk;
    it.left_justify = lj;
    it.zero_pad = zp;
    it.has_precision = hp;
    it.precision = prec;
    it.field_width = w;
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input bit typed, input string text);
    dir_row_t r;
    r.item = it;
    r.typed = typed;
    r.text = text;
    dir_rows.push_back(r);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [63:0] full;
    full = {$urandom, $urandom};
    it = in_item_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 5))
      0: it.value = 64'($urandom_range(0, 300));
      1: it.value = 64'd0;
      2: it.value = '1;
      3: it.value = full >> $urandom_range(0, 63);
      default: it.value = full;
    endcase
    case ($urandom_range(0, 4))
      0: it.radix = RADIX_MIN;
      1: it.radix = RADIX_DEC;
      2: it.radix = RADIX_MAX;
      3: it.radix = 5'($urandom_range(0, 31));
      default: it.radix = 5'($urandom_range(8, 16));
    endcase
    // mostly short fields; now and then the whole range incl. saturation
    if ($urandom_range(0, 3) != 0) it.field_width = 6'($urandom_range(0, 20));
    if ($urandom_range(0, 3) != 0) it.precision = 6'($urandom_range(0, 24));
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input string text);
    out_item_t ex;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        ex.out_char = text[i];
        ex.last = (i == text.len() - 1);
        pending_chars.push_back(ex);
      end
    end else begin
      format_field(it);
    end
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // result side: check each accepted beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t ex;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got char %h last %b",
                 $time, out_data.out_char, out_data.last);
      end else begin
        ex = pending_chars.pop_front();
        if (out_data.out_char !== ex.out_char) begin
          errors++;
          $display("%0t: out_char expected %h got %h", $time, ex.out_char, out_data.out_char);
        end
        if (out_data.last !== ex.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, ex.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("integer_field_formatter_unit regression: fail");
      $finish;
    end
  end

  initial begin : out_pacing
    int n;
    out_stall = 1'b0;
    forever begin
      if (!rst_n || quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    cycles = 0;
    quiet_tail = 1'b0;

    // value, radix, upper, sign, prefix, left, zero, has_prec, prec, width
    add_row(fmt_item(64'd0, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 0), 1, "0");
    add_row(fmt_item(64'd0, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 1, 0, 0), 1, "");
    add_row(fmt_item(64'd0, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 1, 0, 5), 1, "     ");
    add_row(fmt_item(64'd0, RADIX_MAX, 0, SIGN_PLUS, PFX_NONE, 0, 0, 1, 0, 0), 1, "+");
    add_row(fmt_item('1, RADIX_MAX, 0, SIGN_NONE, PFX_LOWER, 0, 0, 0, 0, 0), 1,
            "0xffffffffffffffff");
    add_row(fmt_item('1, RADIX_MAX, 1, SIGN_NONE, PFX_UPPER, 0, 0, 0, 0, 0), 1,
            "0XFFFFFFFFFFFFFFFF");
    add_row(fmt_item('1, RADIX_MIN, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 0), 1,
            "1777777777777777777777");
    add_row(fmt_item('1, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 0), 1,
            "18446744073709551615");
    add_row(fmt_item(64'd8, 5'd0, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 0), 1, "10");
    add_row(fmt_item(64'd255, 5'd31, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 0), 1, "ff");
    add_row(fmt_item(64'd42, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 1, 1, 0, 0, 6), 1, "42    ");
    add_row(fmt_item(64'h2a, RADIX_MAX, 0, SIGN_MINUS, PFX_LOWER, 0, 1, 0, 0, 8), 1,
            "-0x0002a");
    add_row(fmt_item(64'd7, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 1, 1, 3, 6), 1, "   007");
    add_row(fmt_item(64'd5, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 10, 0), 1, "5");
    add_row(fmt_item(64'd10, RADIX_MAX, 0, SIGN_NONE, PFX_RSVD, 0, 0, 0, 0, 0), 1, "a");
    add_row(fmt_item(64'd9, RADIX_DEC, 0, SIGN_SPACE, PFX_NONE, 0, 0, 0, 0, 0), 1, " 9");
    add_row(fmt_item(64'd1234567890, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 12), 1,
            "  1234567890");
    add_row(fmt_item(64'd1, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 0, 0, 1, 63, 0), 0, "");
    add_row(fmt_item(64'd3, RADIX_MIN, 0, SIGN_NONE, PFX_NONE, 0, 0, 0, 0, 63), 0, "");
    add_row(fmt_item(64'd0, RADIX_DEC, 0, SIGN_NONE, PFX_NONE, 1, 0, 0, 0, 48), 0, "");
    add_row(fmt_item('1, RADIX_MAX, 1, SIGN_PLUS, PFX_UPPER, 0, 0, 1, 40, 48), 0, "");
    add_row(fmt_item(64'habcdef, RADIX_MAX, 1, SIGN_PLUS, PFX_UPPER, 0, 0, 1, 8, 0), 0, "");
    add_row(fmt_item(64'hfedcba9876543210, 5'd12, 1, SIGN_MINUS, PFX_LOWER, 0, 1, 0, 0, 40),
            0, "");
    add_row(fmt_item(64'd0, RADIX_MIN, 0, SIGN_SPACE, PFX_UPPER, 0, 1, 0, 0, 7), 0, "");
    add_row(fmt_item(64'h8000000000000000, 5'd13, 0, SIGN_NONE, PFX_NONE, 1, 0, 1, 30, 33),
            0, "");

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].text);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      send_item(rand_item(), 0, "");
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("integer_field_formatter_unit regression: pass");
    end else begin
      $display("integer_field_formatter_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ifmt_pkg.sv
rtl/core/ifmt_divider.sv
rtl/core/ifmt_digit_stack.sv
rtl/core/integer_field_formatter_unit.sv
sim/tb_integer_field_formatter_unit.sv
